>>> hw/rtl/tmbd_pkg.sv
// ----------------------------------------------------------------------------
// tmbd_pkg: shared types and constants of the trail map blur/decay block
// Geometry limits, field widths, register indexes and the control word that
// follows each accepted word down the filter pipeline.
// ----------------------------------------------------------------------------
package tmbd_pkg;

    localparam int MAX_LINE_LENGTH = 2048;
    localparam int MAX_LINE_COUNT  = 4096;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int POS_W  = $clog2(MAX_LINE_LENGTH);   // column index
    localparam int LINE_W = $clog2(MAX_LINE_COUNT);    // line index
    localparam int LEN_W  = POS_W + 1;                 // holds the line length itself
    localparam int CNT_W  = LINE_W + 1;                // holds the line count itself

    // configuration port
    localparam int CFG_LEN_W  = 12;
    localparam int CFG_CNT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd1;

    // result queue
    localparam int OQ_DEPTH = 16;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OCC_W    = $clog2(OQ_DEPTH + 1);

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [LINE_W-1:0] line_t;
    typedef logic [PIX_W-1:0]  pix_t;

    // per-word control decided at acceptance
    typedef struct packed {
        logic pixel;   // real pixel: touches line store and window
        logic emit;    // word produces a result
        logic black;   // result is forced to black
        logic last;    // result is the last of its frame
    } item_ctl_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } result_t;

endpackage

>>> hw/rtl/tmbd_ram.sv
// ----------------------------------------------------------------------------
// tmbd_ram: simple dual-port synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tmbd_ram #(
    parameter int DATA_W = 48,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/tmbd_ctrl.sv
// ----------------------------------------------------------------------------
// tmbd_ctrl: geometry registers and scan bookkeeping
// Tracks input position, output position and the owed frame tail, and
// classifies each offered word (pixel/padding, result, black, last).
// ----------------------------------------------------------------------------
module tmbd_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tmbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmbd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             acc,
    input  logic                             is_pixel,
    output tmbd_pkg::item_ctl_t              ctl,
    output tmbd_pkg::pos_t                   rd_addr,
    output logic                             restart
);

    import tmbd_pkg::*;

    localparam int LEN_RESET = 1080;
    localparam int CNT_RESET = 1920;

    function automatic len_t sat_len(logic [CFG_LEN_W-1:0] v);
        len_t r;
        if (v < CFG_LEN_W'(3)) begin
            r = len_t'(3);
        end else if (v > CFG_LEN_W'(MAX_LINE_LENGTH)) begin
            r = len_t'(MAX_LINE_LENGTH);
        end else begin
            r = len_t'(v);
        end
        return r;
    endfunction

    function automatic cnt_t sat_cnt(logic [CFG_CNT_W-1:0] v);
        cnt_t r;
        if (v < CFG_CNT_W'(3)) begin
            r = cnt_t'(3);
        end else if (v > CFG_CNT_W'(MAX_LINE_COUNT)) begin
            r = cnt_t'(MAX_LINE_COUNT);
        end else begin
            r = cnt_t'(v);
        end
        return r;
    endfunction

    len_t  w_reg, w_next;
    cnt_t  h_reg, h_next;
    pos_t  pos_reg, pos_next;
    line_t line_reg, line_next;
    pos_t  ocol_reg, ocol_next;
    line_t oline_reg, oline_next;
    len_t  tail_reg, tail_next;

    logic at_end, last_line, tail_pend, body_emit, border, out_end, out_last_line;

    assign restart = cfg_wr_en &&
                     (cfg_index == REG_LINE_LENGTH || cfg_index == REG_LINE_COUNT);
    assign rd_addr = pos_reg;

    always_comb begin
        at_end        = (len_t'(pos_reg) + len_t'(1)) == w_reg;
        last_line     = (cnt_t'(line_reg) + cnt_t'(1)) == h_reg;
        out_end       = len_t'(ocol_reg) == (w_reg - len_t'(1));
        out_last_line = cnt_t'(oline_reg) == (h_reg - cnt_t'(1));
        tail_pend     = tail_reg != '0;
        // one line plus one pixel must be in before the first result
        body_emit     = (line_reg >= line_t'(2)) ||
                        (line_reg == line_t'(1) && pos_reg != '0);
        border        = oline_reg == '0 || out_last_line || ocol_reg == '0 || out_end;

        ctl.pixel = is_pixel;
        ctl.emit  = tail_pend || (is_pixel && body_emit);
        ctl.black = tail_pend || border;
        ctl.last  = out_end && out_last_line;
    end

    always_comb begin
        w_next     = w_reg;
        h_next     = h_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        ocol_next  = ocol_reg;
        oline_next = oline_reg;
        tail_next  = tail_reg;
        if (restart) begin
            if (cfg_index == REG_LINE_LENGTH) begin
                w_next = sat_len(cfg_data[CFG_LEN_W-1:0]);
            end else begin
                h_next = sat_cnt(cfg_data[CFG_CNT_W-1:0]);
            end
            pos_next   = '0;
            line_next  = '0;
            ocol_next  = '0;
            oline_next = '0;
            tail_next  = '0;
        end else if (acc) begin
            if (ctl.emit) begin
                if (out_end) begin
                    ocol_next  = '0;
                    oline_next = out_last_line ? '0 : oline_reg + line_t'(1);
                end else begin
                    ocol_next = ocol_reg + pos_t'(1);
                end
                if (tail_pend) begin
                    tail_next = tail_reg - len_t'(1);
                end
            end
            if (is_pixel) begin
                if (at_end) begin
                    pos_next = '0;
                    if (last_line) begin
                        line_next = '0;
                        tail_next = w_reg + len_t'(1);
                    end else begin
                        line_next = line_reg + line_t'(1);
                    end
                end else begin
                    pos_next = pos_reg + pos_t'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg     <= len_t'(LEN_RESET);
            h_reg     <= cnt_t'(CNT_RESET);
            pos_reg   <= '0;
            line_reg  <= '0;
            ocol_reg  <= '0;
            oline_reg <= '0;
            tail_reg  <= '0;
        end else begin
            w_reg     <= w_next;
            h_reg     <= h_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            ocol_reg  <= ocol_next;
            oline_reg <= oline_next;
            tail_reg  <= tail_next;
        end
    end

    a_pos_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        len_t'(pos_reg) < w_reg && len_t'(ocol_reg) < w_reg)
        else $error("column index outside line");

    a_tail_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, tail_reg} <= {1'b0, w_reg} + (LEN_W+1)'(1))
        else $error("owed tail exceeds one line plus one");

endmodule

>>> hw/rtl/tmbd_filter.sv
// ----------------------------------------------------------------------------
// tmbd_filter: line store, 3x3 window and blur/decay datapath
// Reads both stored lines at the pixel column, writes them back shifted,
// slides the window and runs the per-channel arithmetic over four stages.
// ----------------------------------------------------------------------------
module tmbd_filter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 restart,
    input  logic                 in_acc,
    input  tmbd_pkg::item_ctl_t  in_ctl,
    input  tmbd_pkg::pos_t       in_addr,
    input  tmbd_pkg::pix_t       in_pix,
    output logic                 res_valid,
    output tmbd_pkg::result_t    res
);

    import tmbd_pkg::*;

    localparam int SUM_W = CH_W + 3;            // eight taps
    localparam int MID_W = CH_W + 2;            // 2*centre + n
    localparam logic [SUM_W-1:0] DIV9_MUL = 11'd1821;
    localparam int DIV9_SHIFT = 14;
    localparam logic [MID_W-1:0] DIV3_MUL = 10'd683;
    localparam int DIV3_SHIFT = 11;
    localparam logic [15:0] DECAY_MUL = 16'd64881;  // 0.99 in Q16, rounded up
    localparam int DECAY_SHIFT = 16;
    localparam int P9_W = 2 * SUM_W;
    localparam int P3_W = 2 * MID_W;
    localparam int PD_W = CH_W + 16;

    // stage 1: line store data arrives
    logic      v1_reg;
    item_ctl_t ctl1_reg;
    pos_t      addr1_reg;
    pix_t      pix1_reg;
    logic [2*PIX_W-1:0] rd_data;
    logic      wr_en;

    // window, row 0 = oldest line, column 2 = newest
    pix_t win_reg  [3][3];
    pix_t win_next [3][3];

    // stages 2..6
    logic v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic blk2_reg, blk3_reg, blk4_reg, blk5_reg;
    logic lst2_reg, lst3_reg, lst4_reg, lst5_reg, lst6_reg;
    logic [SUM_W-1:0] sum3_reg [3];
    logic [SUM_W-1:0] sum_next [3];
    logic [CH_W-1:0]  cen3_reg [3];
    logic [CH_W-1:0]  cen4_reg [3];
    logic [CH_W-1:0]  n4_reg   [3];
    logic [CH_W-1:0]  n_next   [3];
    logic [CH_W-1:0]  m5_reg   [3];
    logic [CH_W-1:0]  m_next   [3];
    logic [CH_W-1:0]  o6_reg   [3];
    logic [CH_W-1:0]  o_next   [3];
    logic [P9_W-1:0]  p9 [3];
    logic [MID_W-1:0] x3 [3];
    logic [P3_W-1:0]  p3 [3];
    logic [PD_W-1:0]  pd [3];

    assign wr_en = v1_reg && ctl1_reg.pixel;

    tmbd_ram #(
        .DATA_W (2 * PIX_W),
        .ADDR_W (POS_W)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (addr1_reg),
        .wr_data ({rd_data[PIX_W-1:0], pix1_reg}),   // middle moves up, new pixel in
        .rd_en   (in_acc && in_ctl.pixel),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                win_next[r][c] = win_reg[r][c];
            end
        end
        if (restart) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_next[r][c] = '0;
                end
            end
        end else if (wr_en) begin
            for (int r = 0; r < 3; r++) begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[0][2] = rd_data[2*PIX_W-1:PIX_W];
            win_next[1][2] = rd_data[PIX_W-1:0];
            win_next[2][2] = pix1_reg;
        end
    end

    // channel k: 0 = blue, 1 = green, 2 = red
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum_next[k] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (r != 1 || c != 1) begin
                        sum_next[k] = sum_next[k] + SUM_W'(win_reg[r][c][k*CH_W +: CH_W]);
                    end
                end
            end
            p9[k]     = P9_W'(sum3_reg[k]) * P9_W'(DIV9_MUL);
            n_next[k] = p9[k][DIV9_SHIFT +: CH_W];
            x3[k]     = MID_W'({cen4_reg[k], 1'b0}) + MID_W'(n4_reg[k]);
            p3[k]     = P3_W'(x3[k]) * P3_W'(DIV3_MUL);
            m_next[k] = p3[k][DIV3_SHIFT +: CH_W];
            pd[k]     = PD_W'(m5_reg[k]) * PD_W'(DECAY_MUL);
            o_next[k] = blk5_reg ? '0 : pd[k][DECAY_SHIFT +: CH_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else begin
            v1_reg <= in_acc;
            v2_reg <= v1_reg && ctl1_reg.emit;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        ctl1_reg  <= in_ctl;
        addr1_reg <= in_addr;
        pix1_reg  <= in_pix;
        blk2_reg  <= ctl1_reg.black;
        lst2_reg  <= ctl1_reg.last;
        blk3_reg  <= blk2_reg;
        lst3_reg  <= lst2_reg;
        blk4_reg  <= blk3_reg;
        lst4_reg  <= lst3_reg;
        blk5_reg  <= blk4_reg;
        lst5_reg  <= lst4_reg;
        lst6_reg  <= lst5_reg;
        for (int k = 0; k < 3; k++) begin
            sum3_reg[k] <= sum_next[k];
            cen3_reg[k] <= win_reg[1][1][k*CH_W +: CH_W];
            n4_reg[k]   <= n_next[k];
            cen4_reg[k] <= cen3_reg[k];
            m5_reg[k]   <= m_next[k];
            o6_reg[k]   <= o_next[k];
        end
    end

    assign res_valid = v6_reg;
    assign res.red   = o6_reg[2];
    assign res.green = o6_reg[1];
    assign res.blue  = o6_reg[0];
    assign res.last  = lst6_reg;

endmodule

>>> hw/rtl/tmbd_outq.sv
// ----------------------------------------------------------------------------
// tmbd_outq: result queue
// Small first-in first-out store between the datapath and the result port.
// ----------------------------------------------------------------------------
module tmbd_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  tmbd_pkg::result_t  push_data,
    input  logic               pop,
    output logic               out_valid,
    output tmbd_pkg::result_t  out_data
);

    import tmbd_pkg::*;

    result_t             mem [OQ_DEPTH];
    logic [OQ_AW-1:0]    wp_reg, wp_next;
    logic [OQ_AW-1:0]    rp_reg, rp_next;
    logic [OCC_W-1:0]    cnt_reg, cnt_next;
    logic                full;

    assign out_valid = cnt_reg != '0;
    assign full      = cnt_reg == OCC_W'(OQ_DEPTH);
    assign out_data  = mem[rp_reg];

    always_comb begin
        wp_next  = push ? wp_reg + OQ_AW'(1) : wp_reg;
        rp_next  = pop  ? rp_reg + OQ_AW'(1) : rp_reg;
        cnt_next = cnt_reg + OCC_W'(push) - OCC_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> out_valid)
        else $error("result queue underflow");

endmodule

>>> hw/rtl/trail_map_blur_decay.sv
// ----------------------------------------------------------------------------
// trail_map_blur_decay: 3x3 neighbourhood blur with decay on RGB888 pixels
// Scan-order frame in, one filtered pixel out per pixel once a line plus one
// pixel has been seen; border centres come out black, padding drains the tail.
// ----------------------------------------------------------------------------
//
//  port group   role        handshake           payload
//  s_*          pixel in    s_valid / s_ready   s_is_pixel, s_red_in/green/blue
//  m_*          result out  m_valid / m_ready   m_red_out/green/blue, m_frame_last
//  cfg_*        geometry    cfg_wr_en           cfg_index, cfg_data
//
//  One word per clock in and out while s_ready and m_ready allow. From input
//  acceptance to the result at the output queue head: the line store is read
//  at acceptance and its data registered, then window slide, tap sum, divide
//  by nine, blend, decay and queue write follow in order, each registered.
//  The line store is one 2048 x 48 RAM holding the upper and middle lines per
//  column; a column is read when its pixel is accepted and written in the cycle
//  after, and the same column comes back no sooner than three words later.
//  Reset is synchronous, active low; it clears control state and the window.
//  The line store needs no clearing pass. s_ready depends only on the count of
//  results reserved in the 16-entry output queue, never on m_ready, so m_ready
//  low stalls the input only once the queue is full.
// ----------------------------------------------------------------------------
module trail_map_blur_decay (
    input  logic                             aclk,
    input  logic                             aresetn,
    // pixel input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_is_pixel,
    input  logic [tmbd_pkg::CH_W-1:0]        s_red_in,
    input  logic [tmbd_pkg::CH_W-1:0]        s_green_in,
    input  logic [tmbd_pkg::CH_W-1:0]        s_blue_in,
    // result output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tmbd_pkg::CH_W-1:0]        m_red_out,
    output logic [tmbd_pkg::CH_W-1:0]        m_green_out,
    output logic [tmbd_pkg::CH_W-1:0]        m_blue_out,
    output logic                             m_frame_last,
    // configuration
    input  logic                             cfg_wr_en,
    input  logic [tmbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import tmbd_pkg::*;

    logic             s_acc;
    logic             m_pop;
    item_ctl_t        ctl;
    pos_t             rd_addr;
    logic             restart;
    logic             res_valid;
    result_t          res;
    result_t          q_data;
    logic [OCC_W-1:0] occ_reg, occ_next;

    // occupancy counts results in flight plus results queued; reserve a
    // queue slot at acceptance so the pipeline never has to stall
    assign s_ready = occ_reg < OCC_W'(OQ_DEPTH);
    assign s_acc   = s_valid && s_ready;
    assign m_pop   = m_valid && m_ready;

    always_comb begin
        occ_next = occ_reg + OCC_W'(s_acc && ctl.emit) - OCC_W'(m_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // scan bookkeeping and geometry registers
    tmbd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .acc       (s_acc),
        .is_pixel  (s_is_pixel),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .restart   (restart)
    );

    // line store, window and arithmetic
    tmbd_filter u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .in_acc    (s_acc),
        .in_ctl    (ctl),
        .in_addr   (rd_addr),
        .in_pix    ({s_red_in, s_green_in, s_blue_in}),
        .res_valid (res_valid),
        .res       (res)
    );

    // hold finished results until the sink takes them
    tmbd_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_pop),
        .out_valid (m_valid),
        .out_data  (q_data)
    );

    assign m_red_out    = q_data.red;
    assign m_green_out  = q_data.green;
    assign m_blue_out   = q_data.blue;
    assign m_frame_last = q_data.last;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(OQ_DEPTH))
        else $error("reserved result slots exceed queue depth");

    a_occ_covers_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> occ_reg != '0)
        else $error("queued result without reservation");

endmodule
